/* design/opd_pkg.sv */
// ----------------------------------------------------------------------------
// OBD-II poll decoder package
// Shared types, codes and tables for the mode 01 parameter poll decoder.
// ----------------------------------------------------------------------------
package opd_pkg;

   typedef logic [1:0]         mode_type;
   typedef logic [10:0]        can_id_type;
   typedef logic [7:0]         byte_type;
   typedef logic [2:0]         slot_type;
   typedef logic signed [16:0] value_type;
   typedef logic [0:0]         csr_index_type;
   typedef logic [10:0]        csr_data_type;

   // Poll outcome codes. The unused code is handled as a timeout.
   localparam mode_type MODE_REPLY   = 2'd0;
   localparam mode_type MODE_TIMEOUT = 2'd1;
   localparam mode_type MODE_TXFAIL  = 2'd2;
   localparam mode_type MODE_SPARE   = 2'd3;

   // Register indexes on the configuration port.
   localparam csr_index_type CSR_MAX_FAIL = 1'd0;
   localparam csr_index_type CSR_REPLY_ID = 1'd1;

   localparam byte_type   MAX_FAIL_RESET = 8'd20;
   localparam can_id_type REPLY_ID_RESET = 11'h7E8;
   localparam byte_type   STREAK_MAX     = 8'd255;

   // Rotation slots, in polling order.
   localparam slot_type SLOT_RPM      = 3'd0;
   localparam slot_type SLOT_SPEED    = 3'd1;
   localparam slot_type SLOT_COOLANT  = 3'd2;
   localparam slot_type SLOT_LOAD     = 3'd3;
   localparam slot_type SLOT_THROTTLE = 3'd4;
   localparam slot_type SLOT_RUNTIME  = 3'd5;

   localparam byte_type PID_RPM      = 8'h0C;
   localparam byte_type PID_SPEED    = 8'h0D;
   localparam byte_type PID_COOLANT  = 8'h05;
   localparam byte_type PID_LOAD     = 8'h04;
   localparam byte_type PID_THROTTLE = 8'h11;
   localparam byte_type PID_RUNTIME  = 8'h1F;

   // Mode 01 parameter identifier polled in each slot.
   function automatic byte_type pid_of_slot(slot_type slot);
      byte_type pid;
      case (slot)
         SLOT_RPM:      pid = PID_RPM;
         SLOT_SPEED:    pid = PID_SPEED;
         SLOT_COOLANT:  pid = PID_COOLANT;
         SLOT_LOAD:     pid = PID_LOAD;
         SLOT_THROTTLE: pid = PID_THROTTLE;
         SLOT_RUNTIME:  pid = PID_RUNTIME;
         default:       pid = PID_RPM;
      endcase
      return pid;
   endfunction

endpackage

/* design/opd_if.sv */
// ----------------------------------------------------------------------------
// OBD-II poll decoder channels
// Valid/ready channels for poll outcomes and decoded results.
// ----------------------------------------------------------------------------
interface opd_req_if;
   logic                valid;
   logic                ready;
   opd_pkg::mode_type   mode;
   opd_pkg::can_id_type resp_id;
   opd_pkg::byte_type   byte_a;
   opd_pkg::byte_type   byte_b;

   modport source (output valid, output mode, output resp_id, output byte_a,
                   output byte_b, input ready);
   modport sink   (input valid, input mode, input resp_id, input byte_a,
                   input byte_b, output ready);
endinterface

interface opd_rsp_if;
   logic                valid;
   logic                ready;
   logic                value_valid;
   opd_pkg::slot_type   param_code;
   opd_pkg::value_type  value;
   logic                link_lost;
   opd_pkg::byte_type   next_pid;
   opd_pkg::byte_type   miss_streak;

   modport source (output valid, output value_valid, output param_code, output value,
                   output link_lost, output next_pid, output miss_streak, input ready);
   modport sink   (input valid, input value_valid, input param_code, input value,
                   input link_lost, input next_pid, input miss_streak, output ready);
endinterface

/* design/opd_value_decode.sv */
// ----------------------------------------------------------------------------
// OBD-II value decoder
// Turns the two reply data bytes into an engineering value for one slot.
// ----------------------------------------------------------------------------
module opd_value_decode (
   input  opd_pkg::slot_type  slot,
   input  opd_pkg::byte_type  byte_a,
   input  opd_pkg::byte_type  byte_b,
   output opd_pkg::value_type value
);
   import opd_pkg::*;

   logic [14:0] pct_scaled;
   logic [16:0] pct_sum;
   logic [8:0]  pct_quot;

   // a*100/255 by reciprocal: x/255 = (x + 1 + (x >> 8)) >> 8 for any x below 65535.
   assign pct_scaled = 15'(byte_a) * 15'd100;
   assign pct_sum    = 17'(pct_scaled) + 17'd1 + 17'(pct_scaled[14:8]);
   assign pct_quot   = pct_sum[16:8];

   always_comb begin
      case (slot)
         SLOT_SPEED:    value = $signed({9'd0, byte_a});
         SLOT_COOLANT:  value = $signed({9'd0, byte_a}) - 17'sd40;
         SLOT_LOAD,
         SLOT_THROTTLE: value = $signed({8'd0, pct_quot});
         SLOT_RUNTIME:  value = $signed({1'b0, byte_a, byte_b});
         default:       value = $signed({3'd0, byte_a, byte_b[7:2]});
      endcase
   end

endmodule

/* design/obd2_pid_poll_decoder_top.sv */
// ----------------------------------------------------------------------------
// OBD-II mode 01 poll decoder, top level
// A word passes the input register, then the result register, and is held
// there only while the result side stalls; rotation and streak update together.
// Throughput: one word per cycle unless the result side stalls.
// Reset (synchronous, active high) empties both stages, restarts the rotation
// at engine speed, clears the miss streak and restores both registers.
// ----------------------------------------------------------------------------
module obd2_pid_poll_decoder_top (
   input  logic                   clock,
   input  logic                   reset,
   opd_req_if.sink                req_ch,
   opd_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  opd_pkg::csr_index_type csr_index,
   input  opd_pkg::csr_data_type  csr_wdata
);
   import opd_pkg::*;

   // Configuration registers.
   byte_type   max_fail_ff;
   can_id_type reply_id_ff;

   // Poller state: rotation slot and consecutive miss count.
   slot_type rotation_ff, rotation_in;
   byte_type fail_ff, fail_in;

   // Input register stage.
   logic       in_valid_ff;
   mode_type   in_mode_ff;
   can_id_type in_id_ff;
   byte_type   in_a_ff, in_b_ff;

   // Result register stage.
   logic       out_valid_ff;
   logic       out_vvalid_ff, out_vvalid_in;
   slot_type   out_code_ff;
   value_type  out_value_ff, out_value_in;
   logic       out_lost_ff, out_lost_in;
   byte_type   out_pid_ff;
   byte_type   out_streak_ff;

   logic       advance;
   logic       out_free;
   slot_type   slot;
   logic       hit;
   byte_type   streak_inc;
   value_type  decoded;

   // The result register is free when empty or being drained this cycle. The
   // input register hands its word on whenever the result register is free,
   // so a new word may enter every cycle while the output is not held.
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;

   // Slots six and seven never occur but would poll engine speed.
   assign slot = (rotation_ff > SLOT_RUNTIME) ? SLOT_RPM : rotation_ff;

   opd_value_decode u_decode (
      .slot   (slot),
      .byte_a (in_a_ff),
      .byte_b (in_b_ff),
      .value  (decoded)
   );

   // A reply counts only when it comes from the configured identifier; any
   // other reply, a timeout or the unused mode code counts as a miss. The
   // streak saturates rather than wrapping.
   always_comb begin
      hit           = (in_mode_ff == MODE_REPLY) && (in_id_ff == reply_id_ff);
      streak_inc    = (fail_ff == STREAK_MAX) ? STREAK_MAX : fail_ff + 8'd1;
      out_vvalid_in = 1'b0;
      out_value_in  = '0;
      out_lost_in   = 1'b0;
      fail_in       = fail_ff;

      if (in_mode_ff == MODE_TXFAIL) begin
         out_lost_in = 1'b1;
      end else if (hit) begin
         fail_in       = '0;
         out_vvalid_in = 1'b1;
         out_value_in  = decoded;
      end else begin
         fail_in     = streak_inc;
         out_lost_in = (streak_inc >= max_fail_ff);
      end

      // Losing the link restarts the rotation and the streak; otherwise the
      // rotation moves on by one slot after every poll.
      if (out_lost_in) begin
         rotation_in = SLOT_RPM;
         fail_in     = '0;
      end else if (slot == SLOT_RUNTIME) begin
         rotation_in = SLOT_RPM;
      end else begin
         rotation_in = slot + 3'd1;
      end
   end

   // Configuration writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_fail_ff <= MAX_FAIL_RESET;
         reply_id_ff <= REPLY_ID_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_FAIL: max_fail_ff <= csr_wdata[7:0];
            CSR_REPLY_ID: reply_id_ff <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // Control state: stage valid flags and the poller state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         rotation_ff  <= SLOT_RPM;
         fail_ff      <= '0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            rotation_ff <= rotation_in;
            fail_ff     <= fail_in;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_mode_ff <= req_ch.mode;
         in_id_ff   <= req_ch.resp_id;
         in_a_ff    <= req_ch.byte_a;
         in_b_ff    <= req_ch.byte_b;
      end
      if (advance) begin
         out_vvalid_ff <= out_vvalid_in;
         out_code_ff   <= slot;
         out_value_ff  <= out_value_in;
         out_lost_ff   <= out_lost_in;
         out_pid_ff    <= pid_of_slot(rotation_in);
         out_streak_ff <= fail_in;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.value_valid = out_vvalid_ff;
   assign rsp_ch.param_code  = out_code_ff;
   assign rsp_ch.value       = out_value_ff;
   assign rsp_ch.link_lost   = out_lost_ff;
   assign rsp_ch.next_pid    = out_pid_ff;
   assign rsp_ch.miss_streak = out_streak_ff;

   // A decoded value means the link was kept.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.value_valid && rsp_ch.link_lost))
      else $error("value decoded on a step that lost the link");

   // Link loss restarts the rotation and clears the streak.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.link_lost) |->
         (rsp_ch.next_pid == PID_RPM && rsp_ch.miss_streak == 8'd0))
      else $error("link loss did not restart the poll rotation");

   // A successful reply always clears the streak.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.value_valid) |-> rsp_ch.miss_streak == 8'd0)
      else $error("streak not cleared by a good reply");

   // The rotation never leaves the six defined slots.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rotation_ff <= SLOT_RUNTIME)
      else $error("rotation slot out of range");

endmodule

/* test/obd2_pid_poll_decoder_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// OBD-II mode 01 poll decoder testbench
// Feeds poll outcomes (replies, timeouts, transmit failures) to the decoder,
// predicts each result word from a behavioural copy of the rotation and miss
// streak, and checks every result word field by field, in order, across
// several register settings and handshake idling profiles.
// ----------------------------------------------------------------------------
module obd2_pid_poll_decoder_top_tb;
   import opd_pkg::*;

   // The decoder never takes long: input and result register plus receiver stalls.
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      mode_type   mode;
      can_id_type resp_id;
      byte_type   byte_a;
      byte_type   byte_b;
   } poll_word_type;

   typedef struct packed {
      logic       value_valid;
      slot_type   param_code;
      value_type  value;
      logic       link_lost;
      byte_type   next_pid;
      byte_type   miss_streak;
   } result_word_type;

   // The scoreboard holds its own copy of the registers, the rotation slot
   // and the miss streak. Each accepted poll word is turned into the result
   // word the decoder should produce, and result words are checked in order.
   class poll_scoreboard;
      byte_type        max_fail;
      can_id_type      reply_id;
      slot_type        slot;
      byte_type        streak;
      byte_type        pid_by_slot [6];
      result_word_type expected_results [$];
      int              error_count;

      function new();
         max_fail    = MAX_FAIL_RESET;
         reply_id    = REPLY_ID_RESET;
         slot        = SLOT_RPM;
         streak      = '0;
         error_count = 0;
         pid_by_slot = '{PID_RPM, PID_SPEED, PID_COOLANT, PID_LOAD, PID_THROTTLE,
                         PID_RUNTIME};
      endfunction

      function void set_register(csr_index_type index, csr_data_type data);
         if (index == CSR_MAX_FAIL) begin
            max_fail = data[7:0];
         end else if (index == CSR_REPLY_ID) begin
            reply_id = data;
         end
      endfunction

      function value_type decode_reading(slot_type s, byte_type a, byte_type b);
         int reading;
         case (s)
            SLOT_RPM:      reading = ((int'(a) << 8) + int'(b)) >> 2;
            SLOT_SPEED:    reading = int'(a);
            SLOT_COOLANT:  reading = int'(a) - 40;
            SLOT_LOAD,
            SLOT_THROTTLE: reading = (int'(a) * 100) / 255;
            default:       reading = (int'(a) << 8) + int'(b);
         endcase
         return value_type'(reading);
      endfunction

      function result_word_type predict_result(poll_word_type w);
         result_word_type r;
         slot_type        polled;
         r = '0;
         // Slots beyond the runtime one cannot occur, but would poll engine speed.
         polled = (slot <= SLOT_RUNTIME) ? slot : SLOT_RPM;
         r.param_code = polled;
         if (w.mode == MODE_TXFAIL) begin
            r.link_lost = 1'b1;
         end else if (w.mode == MODE_REPLY && w.resp_id == reply_id) begin
            streak        = '0;
            r.value_valid = 1'b1;
            r.value       = decode_reading(polled, w.byte_a, w.byte_b);
         end else begin
            // Timeouts, the unused mode code and foreign replies all count as
            // misses; the streak saturates rather than wrapping.
            if (streak != STREAK_MAX) begin
               streak = streak + 8'd1;
            end
            if (streak >= max_fail) begin
               r.link_lost = 1'b1;
            end
         end
         if (r.link_lost) begin
            slot   = SLOT_RPM;
            streak = '0;
         end else begin
            slot = (polled == SLOT_RUNTIME) ? SLOT_RPM : slot_type'(polled + 3'd1);
         end
         r.next_pid    = pid_by_slot[slot];
         r.miss_streak = streak;
         return r;
      endfunction

      function void note_poll(poll_word_type w);
         expected_results.push_back(predict_result(w));
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void report_mismatch(string field, logic signed [31:0] expected_v,
                                    logic signed [31:0] actual_v);
         $error("%s mismatch: expected %0d, actual %0d", field, expected_v, actual_v);
         error_count++;
      endfunction

      function void check_result(result_word_type got);
         result_word_type exp;
         if (expected_results.size() == 0) begin
            $error("result word arrived with no expectation waiting");
            error_count++;
            return;
         end
         exp = expected_results.pop_front();
         if (got.value_valid !== exp.value_valid)
            report_mismatch("value_valid", exp.value_valid, got.value_valid);
         if (got.param_code !== exp.param_code)
            report_mismatch("param_code", exp.param_code, got.param_code);
         if (got.value !== exp.value)
            report_mismatch("value", exp.value, got.value);
         if (got.link_lost !== exp.link_lost)
            report_mismatch("link_lost", exp.link_lost, got.link_lost);
         if (got.next_pid !== exp.next_pid)
            report_mismatch("next_pid", exp.next_pid, got.next_pid);
         if (got.miss_streak !== exp.miss_streak)
            report_mismatch("miss_streak", exp.miss_streak, got.miss_streak);
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          csr_we;
   csr_index_type csr_index;
   csr_data_type  csr_wdata;

   opd_req_if req_bus ();
   opd_rsp_if rsp_bus ();

   poll_scoreboard sb;
   int             send_idle_pct;
   int             rsp_idle_pct;
   int             cycle_count;

   obd2_pid_poll_decoder_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver stalls at random; the percentage is changed per phase.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Both handshakes are sampled at the rising edge, before any of the
   // nonblocking updates made at that edge take effect, so the monitor sees
   // exactly what the decoder sees. Inputs are noted before results are
   // checked, although the input and result registers keep them apart anyway.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            sb.note_poll('{req_bus.mode, req_bus.resp_id, req_bus.byte_a,
                           req_bus.byte_b});
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_result('{rsp_bus.value_valid, rsp_bus.param_code, rsp_bus.value,
                              rsp_bus.link_lost, rsp_bus.next_pid, rsp_bus.miss_streak});
         end
      end
   end

   // Watchdog: a run that stops making progress ends here as a failure.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // Offers one poll word and returns at the edge where it is accepted, with
   // valid still high so that the next word can follow without a gap. The
   // sender may first idle at random, with valid low while it does.
   task automatic send_word(poll_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.mode    <= w.mode;
      req_bus.resp_id <= w.resp_id;
      req_bus.byte_a  <= w.byte_a;
      req_bus.byte_b  <= w.byte_b;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Lowers valid and holds off until every predicted result word is back.
   // It always waits for the clock before checking, so valid is never assigned
   // twice at the same edge.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Registers are only written while the decoder is idle, so the predictor
   // can take the new value at once.
   task automatic csr_write(csr_index_type index, csr_data_type data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      sb.set_register(index, data);
   endtask

   // Data bytes lean towards their extremes now and then.
   function automatic byte_type random_byte();
      if ($urandom_range(9) == 0) begin
         return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      end
      return byte_type'($urandom_range(255));
   endfunction

   // Most words are replies from the accepted identifier, so the rotation
   // runs through every parameter; the rest are misses of every kind and
   // transmit failures. With misses_only set, the streak simply builds up.
   function automatic poll_word_type random_poll(bit misses_only);
      poll_word_type w;
      int            pick;
      w.resp_id = can_id_type'($urandom_range(2047));
      w.byte_a  = random_byte();
      w.byte_b  = random_byte();
      pick      = $urandom_range(99);
      if (misses_only) begin
         pick = 62 + pick / 4;
      end
      if (pick < 62) begin
         w.mode    = MODE_REPLY;
         w.resp_id = sb.reply_id;
      end else if (pick < 74) begin
         w.mode = MODE_TIMEOUT;
      end else if (pick < 79) begin
         // The unused code behaves as a timeout.
         w.mode = MODE_SPARE;
      end else if (pick < 90) begin
         w.mode = MODE_REPLY;
         if (w.resp_id == sb.reply_id) begin
            w.resp_id = w.resp_id ^ can_id_type'(1 << $urandom_range(10));
         end
      end else begin
         w.mode = MODE_TXFAIL;
      end
      return w;
   endfunction

   // One random phase: registers set while idle, then a stream of words.
   // Now and again the sender holds off until the pipeline is empty.
   task automatic run_phase(byte_type limit, can_id_type id, int count,
                            bit misses_only, int send_pct, int rsp_pct);
      wait_drained();
      csr_write(CSR_MAX_FAIL, csr_data_type'(limit));
      csr_write(CSR_REPLY_ID, id);
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(149) == 0) begin
            wait_drained();
         end
         send_word(random_poll(misses_only));
      end
   endtask

   initial begin
      sb = new();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      reset           <= 1'b1;
      csr_we          <= 1'b0;
      csr_index       <= CSR_MAX_FAIL;
      csr_wdata       <= '0;
      req_bus.valid   <= 1'b0;
      req_bus.mode    <= MODE_REPLY;
      req_bus.resp_id <= '0;
      req_bus.byte_a  <= '0;
      req_bus.byte_b  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, at the reset register values. First every parameter
      // with both bytes at their top, then every parameter with both at zero,
      // so the largest engine speed and runtime, full load and throttle and
      // the coldest coolant reading all appear.
      for (int n = 0; n < 6; n++) begin
         send_word('{MODE_REPLY, REPLY_ID_RESET, 8'hFF, 8'hFF});
      end
      for (int n = 0; n < 6; n++) begin
         send_word('{MODE_REPLY, REPLY_ID_RESET, 8'h00, 8'h00});
      end
      // A timeout, the unused code and a foreign reply build up the streak;
      // a transmit failure then drops the link and restarts the rotation.
      send_word('{MODE_TIMEOUT, REPLY_ID_RESET, 8'h12, 8'h34});
      send_word('{MODE_SPARE, REPLY_ID_RESET, 8'h56, 8'h78});
      send_word('{MODE_REPLY, REPLY_ID_RESET ^ 11'h400, 8'h9A, 8'hBC});
      send_word('{MODE_TXFAIL, REPLY_ID_RESET, 8'hDE, 8'hF0});
      // A good reply after misses clears the streak.
      send_word('{MODE_TIMEOUT, 11'h000, 8'h00, 8'h00});
      send_word('{MODE_REPLY, REPLY_ID_RESET, 8'h80, 8'h01});
      send_word('{MODE_REPLY, REPLY_ID_RESET, 8'h7F, 8'hFE});
      // Hold the sender off until every expected word has come back.
      wait_drained();
      send_word('{MODE_REPLY, REPLY_ID_RESET, 8'd40, 8'h55});
      send_word('{MODE_REPLY, REPLY_ID_RESET, 8'hAA, 8'h55});

      // Random part. The receiver idles more than the sender first, then the
      // other way round, and the last phases run with no idling at all.
      // The limits cover a single miss, no misses at all and the saturating
      // top; the long streak phase offers only misses, so the streak climbs
      // all the way to the top before the link is declared lost.
      run_phase(MAX_FAIL_RESET, REPLY_ID_RESET, 150, 1'b0, 38, 52);
      run_phase(8'd1, 11'h000, 200, 1'b0, 38, 52);
      run_phase(STREAK_MAX, 11'h7FF, 300, 1'b1, 38, 52);
      run_phase(8'd0, REPLY_ID_RESET, 150, 1'b0, 52, 38);
      run_phase(8'd3, can_id_type'($urandom_range(2047)), 200, 1'b0, 52, 38);
      run_phase(STREAK_MAX, 11'h555, 200, 1'b0, 52, 38);
      run_phase(8'd8, 11'h2AA, 200, 1'b0, 0, 0);
      run_phase(MAX_FAIL_RESET, REPLY_ID_RESET, 200, 1'b0, 0, 0);

      // Let everything drain, then wait out the DRAIN_CYCLES allowance for strays.
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected result words never arrived", sb.pending());
      end
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
design/opd_pkg.sv
design/opd_if.sv
design/opd_value_decode.sv
design/obd2_pid_poll_decoder_top.sv
test/obd2_pid_poll_decoder_top_tb.sv
